// ===== rtl/core/eitp_pkg.sv =====
package eitp_pkg;

    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_IPV4    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_IP_LEN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_TCP     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_TCP_LEN = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 3'd5;

    localparam logic [15:0] TYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
    localparam logic [7:0]  ETH_HDR_BYTES = 8'd14;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    // smallest payload offset of a good frame: 14 + 20 + 20
    localparam logic [7:0]  MIN_PAYLOAD_OFFSET = 8'd54;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         src_addr;
        logic [31:0]         dst_addr;
        logic [15:0]         src_tcp_port;
        logic [15:0]         dst_tcp_port;
        logic [7:0]          payload_offset;
        logic [15:0]         payload_len;
    } result_t;

endpackage

// ===== rtl/core/eitp_in_stage.sv =====
module eitp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_data,
    output logic       item_last
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data_byte;
            last_reg <= s_last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;
    assign item_last  = last_reg;

endmodule

// ===== rtl/core/eitp_parse.sv =====
module eitp_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output eitp_pkg::result_t result
);
    import eitp_pkg::*;

    logic [7:0]  byte_count_reg,  byte_count_next;
    logic [15:0] ether_type_reg,  ether_type_next;
    logic [3:0]  ip_words_reg,    ip_words_next;
    logic [7:0]  ip_proto_reg,    ip_proto_next;
    logic [15:0] ip_total_reg,    ip_total_next;
    logic [31:0] src_addr_reg,    src_addr_next;
    logic [31:0] dst_addr_reg,    dst_addr_next;
    logic [15:0] tcp_sport_reg,   tcp_sport_next;
    logic [15:0] tcp_dport_reg,   tcp_dport_next;
    logic [3:0]  tcp_words_reg,   tcp_words_next;

    logic [7:0]          pos;
    logic [7:0]          seen;
    logic [7:0]          tcp_start;
    logic [7:0]          tcp_end;
    logic [STATUS_W-1:0] verdict;
    logic [6:0]          hdr_bytes;
    logic [15:0]         hdr_bytes_w;
    logic [15:0]         plen;

    always_comb begin
        pos  = byte_count_reg;
        seen = (pos != COUNT_MAX) ? pos + 8'd1 : pos;

        ether_type_next = ether_type_reg;
        ip_words_next   = ip_words_reg;
        ip_proto_next   = ip_proto_reg;
        ip_total_next   = ip_total_reg;
        src_addr_next   = src_addr_reg;
        dst_addr_next   = dst_addr_reg;
        tcp_sport_next  = tcp_sport_reg;
        tcp_dport_next  = tcp_dport_reg;
        tcp_words_next  = tcp_words_reg;

        if (pos == 8'd12 || pos == 8'd13) begin
            ether_type_next = {ether_type_reg[7:0], data_byte};
        end else if (pos == 8'd14) begin
            ip_words_next = data_byte[3:0];
        end else if (pos == 8'd16 || pos == 8'd17) begin
            ip_total_next = {ip_total_reg[7:0], data_byte};
        end else if (pos == 8'd23) begin
            ip_proto_next = data_byte;
        end else if (pos >= 8'd26 && pos <= 8'd29) begin
            src_addr_next = {src_addr_reg[23:0], data_byte};
        end else if (pos >= 8'd30 && pos <= 8'd33) begin
            dst_addr_next = {dst_addr_reg[23:0], data_byte};
        end

        tcp_start = ETH_HDR_BYTES + {2'b00, ip_words_next, 2'b00};

        // TCP fields only tracked once the IP header length is sane
        if (ip_words_next >= MIN_HDR_WORDS) begin
            if (pos == tcp_start || pos == tcp_start + 8'd1) begin
                tcp_sport_next = {tcp_sport_reg[7:0], data_byte};
            end else if (pos == tcp_start + 8'd2 || pos == tcp_start + 8'd3) begin
                tcp_dport_next = {tcp_dport_reg[7:0], data_byte};
            end else if (pos == tcp_start + 8'd12) begin
                tcp_words_next = data_byte[7:4];
            end
        end

        tcp_end = tcp_start + {2'b00, tcp_words_next, 2'b00};

        if (seen < 8'd14) begin
            verdict = ST_TRUNCATED;
        end else if (ether_type_next != TYPE_IPV4) begin
            verdict = ST_NOT_IPV4;
        end else if (seen < 8'd15) begin
            verdict = ST_TRUNCATED;
        end else if (ip_words_next < MIN_HDR_WORDS) begin
            verdict = ST_BAD_IP_LEN;
        end else if (seen < 8'd24) begin
            verdict = ST_TRUNCATED;
        end else if (ip_proto_next != PROTO_TCP) begin
            verdict = ST_NOT_TCP;
        end else if (seen < tcp_start + 8'd13) begin
            verdict = ST_TRUNCATED;
        end else if (tcp_words_next < MIN_HDR_WORDS) begin
            verdict = ST_BAD_TCP_LEN;
        end else if (seen < tcp_end) begin
            verdict = ST_TRUNCATED;
        end else begin
            verdict = ST_OK;
        end

        hdr_bytes   = {({1'b0, ip_words_next} + {1'b0, tcp_words_next}), 2'b00};
        hdr_bytes_w = {9'd0, hdr_bytes};
        plen        = (ip_total_next > hdr_bytes_w) ? ip_total_next - hdr_bytes_w : 16'd0;

        result.status         = verdict;
        result.src_addr       = src_addr_next;
        result.dst_addr       = dst_addr_next;
        result.src_tcp_port   = tcp_sport_next;
        result.dst_tcp_port   = tcp_dport_next;
        result.payload_offset = (verdict == ST_OK) ? tcp_end : 8'd0;
        result.payload_len    = (verdict == ST_OK) ? plen : 16'd0;

        byte_count_next = seen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && last_byte)) begin
            byte_count_reg <= '0;
            ether_type_reg <= '0;
            ip_words_reg   <= '0;
            ip_proto_reg   <= '0;
            ip_total_reg   <= '0;
            src_addr_reg   <= '0;
            dst_addr_reg   <= '0;
            tcp_sport_reg  <= '0;
            tcp_dport_reg  <= '0;
            tcp_words_reg  <= '0;
        end else if (fire) begin
            byte_count_reg <= byte_count_next;
            ether_type_reg <= ether_type_next;
            ip_words_reg   <= ip_words_next;
            ip_proto_reg   <= ip_proto_next;
            ip_total_reg   <= ip_total_next;
            src_addr_reg   <= src_addr_next;
            dst_addr_reg   <= dst_addr_next;
            tcp_sport_reg  <= tcp_sport_next;
            tcp_dport_reg  <= tcp_dport_next;
            tcp_words_reg  <= tcp_words_next;
        end
    end

endmodule

// ===== rtl/core/eitp_out_stage.sv =====
module eitp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  eitp_pkg::result_t result_in,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output eitp_pkg::result_t result_out
);
    import eitp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== rtl/core/ethernet_ipv4_tcp_header_parser_top.sv =====
// The last frame byte passes through the input register into the result register, which drives m_valid.
// Throughput: one byte per cycle; a byte is taken every cycle unless the
// result register is still full when a frame's last byte must be reported.
// Reset (aresetn low, synchronous) empties both stages and clears the frame
// state, so the next byte is taken as the first byte of a new frame.
module ethernet_ipv4_tcp_header_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_src_addr,
    output logic [31:0] m_dst_addr,
    output logic [15:0] m_src_tcp_port,
    output logic [15:0] m_dst_tcp_port,
    output logic [7:0]  m_payload_offset,
    output logic [15:0] m_payload_len
);
    import eitp_pkg::*;

    logic       item_valid;
    logic [7:0] item_data;
    logic       item_last;
    logic       take;
    logic       load;
    logic       out_free;
    result_t    parse_result;
    result_t    out_result;

    // a last byte waits in the input register until the result slot is free
    assign take = item_valid && (!item_last || out_free);
    assign load = take && item_last;

    eitp_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .take        (take),
        .item_valid  (item_valid),
        .item_data   (item_data),
        .item_last   (item_last)
    );

    eitp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (take),
        .data_byte (item_data),
        .last_byte (item_last),
        .result    (parse_result)
    );

    eitp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .result_in  (parse_result),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result_out (out_result)
    );

    assign m_status         = out_result.status;
    assign m_src_addr       = out_result.src_addr;
    assign m_dst_addr       = out_result.dst_addr;
    assign m_src_tcp_port   = out_result.src_tcp_port;
    assign m_dst_tcp_port   = out_result.dst_tcp_port;
    assign m_payload_offset = out_result.payload_offset;
    assign m_payload_len    = out_result.payload_len;

    a_bad_frame_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_payload_offset == 8'd0 && m_payload_len == 16'd0)
        else $error("payload fields set on a rejected frame");

    a_good_frame_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_payload_offset >= MIN_PAYLOAD_OFFSET)
        else $error("payload offset below minimum header size");

    a_result_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !load |=> !m_valid)
        else $error("result reported twice");

    a_last_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result register overwritten");

endmodule

// ===== dv/ethernet_ipv4_tcp_header_parser_top_tb.sv =====
module ethernet_ipv4_tcp_header_parser_top_tb;
    import eitp_pkg::*;

    // frame byte offsets of the captured header fields
    localparam int OFS_ETYPE     = 12;
    localparam int OFS_IHL       = 14;
    localparam int OFS_TOTLEN    = 16;
    localparam int OFS_PROTO     = 23;
    localparam int OFS_SADDR     = 26;
    localparam int OFS_DADDR     = 30;
    localparam int TCP_OFS_DOFF  = 12;
    localparam int WORD_BYTES    = 4;

    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int RANDOM_BYTES      = 200;
    localparam int RANDOM_FRAMES_MIN = 5;
    localparam int LONG_HOLD         = 300;
    localparam int DRAIN_CYCLES      = 8;
    localparam int CYCLE_LIMIT       = 500000;
    localparam int MAX_REPORTS       = 40;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    typedef struct packed {
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [15:0] tot_len;
        logic [7:0]  proto;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [3:0]  thl;
        int          payload_n;
        int          cut;
    } frame_spec_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_src_addr;
    logic [31:0] m_dst_addr;
    logic [15:0] m_src_tcp_port;
    logic [15:0] m_dst_tcp_port;
    logic [7:0]  m_payload_offset;
    logic [15:0] m_payload_len;

    ethernet_ipv4_tcp_header_parser_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_src_addr       (m_src_addr),
        .m_dst_addr       (m_dst_addr),
        .m_src_tcp_port   (m_src_tcp_port),
        .m_dst_tcp_port   (m_dst_tcp_port),
        .m_payload_offset (m_payload_offset),
        .m_payload_len    (m_payload_len)
    );

    // parser state mirror
    int          byte_pos;
    logic [15:0] eth_type;
    logic [3:0]  ip_words;
    logic [7:0]  ip_proto;
    logic [15:0] ip_len;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_tcp;
    logic [15:0] dst_tcp;
    logic [3:0]  tcp_words;

    result_t pending_reports[$];
    result_t want;

    int errors          = 0;
    int cycle_cnt       = 0;
    int bytes_sent      = 0;
    int frames_done     = 0;
    int reports_checked = 0;
    int status_hits[8];

    int       burst_left  = 0;
    bit       sender_gaps = 1'b1;
    bit       rx_hold_req = 1'b0;
    int       rx_hold_left = 0;
    int       rx_mode_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic clear_frame();
        byte_pos  = 0;
        eth_type  = '0;
        ip_words  = '0;
        ip_proto  = '0;
        ip_len    = '0;
        src_ip    = '0;
        dst_ip    = '0;
        src_tcp   = '0;
        dst_tcp   = '0;
        tcp_words = '0;
    endtask

    function automatic int tcp_offset();
        return ETH_HDR_BYTES + WORD_BYTES * ip_words;
    endfunction

    // checks in order; each one needs its field to have arrived
    function automatic logic [2:0] frame_status(int seen);
        int t;
        if (seen < OFS_IHL) return ST_TRUNCATED;
        if (eth_type != TYPE_IPV4) return ST_NOT_IPV4;
        if (seen < OFS_IHL + 1) return ST_TRUNCATED;
        if (ip_words < MIN_HDR_WORDS) return ST_BAD_IP_LEN;
        if (seen < OFS_PROTO + 1) return ST_TRUNCATED;
        if (ip_proto != PROTO_TCP) return ST_NOT_TCP;
        t = tcp_offset();
        if (seen < t + TCP_OFS_DOFF + 1) return ST_TRUNCATED;
        if (tcp_words < MIN_HDR_WORDS) return ST_BAD_TCP_LEN;
        if (seen < t + WORD_BYTES * tcp_words) return ST_TRUNCATED;
        return ST_OK;
    endfunction

    task automatic parse_frame_byte(input logic [7:0] b, input logic last);
        int      pos;
        int      t;
        int      hdrs;
        result_t r;
        pos = byte_pos;
        if (byte_pos < COUNT_MAX) byte_pos++;
        if (pos == OFS_ETYPE || pos == OFS_ETYPE + 1) eth_type = {eth_type[7:0], b};
        else if (pos == OFS_IHL) ip_words = b[3:0];
        else if (pos == OFS_TOTLEN || pos == OFS_TOTLEN + 1) ip_len = {ip_len[7:0], b};
        else if (pos == OFS_PROTO) ip_proto = b;
        else if (pos >= OFS_SADDR && pos < OFS_SADDR + 4) src_ip = {src_ip[23:0], b};
        else if (pos >= OFS_DADDR && pos < OFS_DADDR + 4) dst_ip = {dst_ip[23:0], b};
        // TCP fields only land once the IP header length is sane
        if (ip_words >= MIN_HDR_WORDS) begin
            t = tcp_offset();
            if (pos == t || pos == t + 1) src_tcp = {src_tcp[7:0], b};
            else if (pos == t + 2 || pos == t + 3) dst_tcp = {dst_tcp[7:0], b};
            else if (pos == t + TCP_OFS_DOFF) tcp_words = b[7:4];
        end
        if (last) begin
            r              = '0;
            r.status       = frame_status(byte_pos);
            r.src_addr     = src_ip;
            r.dst_addr     = dst_ip;
            r.src_tcp_port = src_tcp;
            r.dst_tcp_port = dst_tcp;
            if (r.status == ST_OK) begin
                hdrs = WORD_BYTES * (ip_words + tcp_words);
                r.payload_offset = 8'(tcp_offset() + WORD_BYTES * tcp_words);
                r.payload_len    = (ip_len > hdrs) ? 16'(ip_len - hdrs) : 16'd0;
            end
            pending_reports.push_back(r);
            status_hits[r.status]++;
            frames_done++;
            clear_frame();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, got status %0d",
                             $time, m_status);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("status", want.status, m_status);
                check_field("src_addr", want.src_addr, m_src_addr);
                check_field("dst_addr", want.dst_addr, m_dst_addr);
                check_field("src_tcp_port", want.src_tcp_port, m_src_tcp_port);
                check_field("dst_tcp_port", want.dst_tcp_port, m_dst_tcp_port);
                check_field("payload_offset", want.payload_offset, m_payload_offset);
                check_field("payload_len", want.payload_len, m_payload_len);
                reports_checked++;
            end
        end
    end

    // receiver: random stall modes, plus one long hold on request
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_left = LONG_HOLD;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(3));
                rx_mode_left = $urandom_range(16, 160);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS:   m_ready <= 1'b1;
                RX_COIN:     m_ready <= 1'($urandom_range(1));
                RX_SPARSE:   m_ready <= ($urandom_range(5) == 0);
                RX_PERIODIC: m_ready <= (cycle_cnt[2:0] != 3'd0);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    // call at a rising edge; returns at the edge where the byte is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (sender_gaps && $urandom_range(3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_frame_byte(b, last);
        bytes_sent++;
    endtask

    function automatic int hdr_words(input logic [3:0] w);
        return (w < MIN_HDR_WORDS) ? MIN_HDR_WORDS : w;
    endfunction

    function automatic int header_bytes(input frame_spec_t fs);
        return OFS_IHL + WORD_BYTES * (hdr_words(fs.ihl) + hdr_words(fs.thl));
    endfunction

    function automatic frame_spec_t random_spec();
        frame_spec_t fs;
        fs.etype     = TYPE_IPV4;
        fs.ihl       = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : MIN_HDR_WORDS;
        fs.thl       = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : MIN_HDR_WORDS;
        fs.proto     = PROTO_TCP;
        fs.saddr     = $urandom;
        fs.daddr     = $urandom;
        fs.sport     = 16'($urandom);
        fs.dport     = 16'($urandom);
        fs.payload_n = $urandom_range(0, 12);
        fs.tot_len   = 16'(WORD_BYTES * (fs.ihl + fs.thl) + fs.payload_n);
        if ($urandom_range(3) == 0) fs.tot_len = 16'($urandom);
        fs.cut       = 0;
        return fs;
    endfunction

    task automatic send_frame(input frame_spec_t fs);
        logic [7:0] fb[$];
        logic [7:0] v;
        int         p;
        int         n;
        fb = {};
        repeat (OFS_ETYPE) fb.push_back(8'($urandom));
        fb.push_back(fs.etype[15:8]);
        fb.push_back(fs.etype[7:0]);
        for (int i = 0; i < WORD_BYTES * hdr_words(fs.ihl); i++) begin
            p = OFS_IHL + i;
            if (p == OFS_IHL) v = {4'h4, fs.ihl};
            else if (p == OFS_TOTLEN) v = fs.tot_len[15:8];
            else if (p == OFS_TOTLEN + 1) v = fs.tot_len[7:0];
            else if (p == OFS_PROTO) v = fs.proto;
            else if (p >= OFS_SADDR && p < OFS_SADDR + 4)
                v = fs.saddr[8 * (OFS_SADDR + 3 - p) +: 8];
            else if (p >= OFS_DADDR && p < OFS_DADDR + 4)
                v = fs.daddr[8 * (OFS_DADDR + 3 - p) +: 8];
            else v = 8'($urandom);
            fb.push_back(v);
        end
        for (int i = 0; i < WORD_BYTES * hdr_words(fs.thl); i++) begin
            if (i < 2) v = fs.sport[8 * (1 - i) +: 8];
            else if (i < 4) v = fs.dport[8 * (3 - i) +: 8];
            else if (i == TCP_OFS_DOFF) v = {fs.thl, 4'($urandom)};
            else v = 8'($urandom);
            fb.push_back(v);
        end
        repeat (fs.payload_n) fb.push_back(8'($urandom));
        n = (fs.cut > 0 && fs.cut < fb.size()) ? fs.cut : fb.size();
        for (int i = 0; i < n; i++) send_byte(fb[i], i == n - 1);
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
    endtask

    task automatic test_good_frames();
        frame_spec_t fs;
        fs = random_spec();
        fs.ihl = MIN_HDR_WORDS; fs.thl = MIN_HDR_WORDS; fs.payload_n = 0;
        fs.saddr = '1; fs.daddr = '1; fs.sport = '1; fs.dport = '1;
        fs.tot_len = 16'd40;
        send_frame(fs);
        fs.saddr = '0; fs.daddr = '0; fs.sport = '0; fs.dport = '0;
        fs.payload_n = 6; fs.tot_len = 16'd46;
        send_frame(fs);
        // largest headers: payload starts at byte 134
        fs = random_spec();
        fs.ihl = 4'hF; fs.thl = 4'hF; fs.payload_n = 3; fs.tot_len = 16'd123;
        send_frame(fs);
    endtask

    task automatic test_length_clamp();
        frame_spec_t fs;
        fs = random_spec();
        fs.tot_len = 16'd0;
        send_frame(fs);
        fs.ihl = MIN_HDR_WORDS; fs.thl = MIN_HDR_WORDS; fs.tot_len = 16'd39;
        send_frame(fs);
        fs.tot_len = 16'hFFFF;
        send_frame(fs);
    endtask

    // each frame ends just after the field that decides its status
    task automatic test_rejections();
        frame_spec_t fs;
        fs = random_spec(); fs.etype = TYPE_IPV6;  fs.cut = 15; send_frame(fs);
        fs = random_spec(); fs.etype = 16'h0000;   fs.cut = 15; send_frame(fs);
        fs = random_spec(); fs.etype = 16'hFFFF;   fs.cut = 15; send_frame(fs);
        fs = random_spec(); fs.ihl = 4'd0;         fs.cut = 16; send_frame(fs);
        fs = random_spec(); fs.ihl = 4'd4;         fs.cut = 16; send_frame(fs);
        fs = random_spec(); fs.proto = PROTO_UDP;  fs.cut = 25; send_frame(fs);
        fs = random_spec(); fs.proto = 8'hFF;      fs.cut = 25; send_frame(fs);
        fs = random_spec(); fs.ihl = MIN_HDR_WORDS; fs.thl = 4'd0; fs.cut = 48; send_frame(fs);
        fs = random_spec(); fs.ihl = MIN_HDR_WORDS; fs.thl = 4'd4; fs.cut = 48; send_frame(fs);
    endtask

    task automatic test_truncation();
        frame_spec_t fs;
        fs = random_spec();
        fs.ihl = MIN_HDR_WORDS; fs.thl = MIN_HDR_WORDS;
        fs.cut = 1;  send_frame(fs);
        fs.cut = 13; send_frame(fs);
        fs.cut = 14; send_frame(fs);   // EtherType complete, IHL missing
        fs.cut = 23; send_frame(fs);   // protocol byte missing
        fs.cut = 46; send_frame(fs);   // data offset byte missing
        fs.etype = TYPE_ARP; fs.cut = 14; send_frame(fs);
        fs.etype = TYPE_IPV4;
        fs.ihl = 4'd4; fs.cut = 15; send_frame(fs);
        fs.ihl = MIN_HDR_WORDS; fs.proto = PROTO_UDP; fs.cut = 24; send_frame(fs);
        fs.proto = PROTO_TCP; fs.thl = 4'd3; fs.cut = 47; send_frame(fs);
        fs.thl = 4'd10; fs.cut = 60; send_frame(fs);     // inside TCP options
        fs.ihl = 4'd8; fs.thl = MIN_HDR_WORDS; fs.cut = 40; send_frame(fs);  // IP options
    endtask

    // runs past the point where the byte counter saturates
    task automatic test_long_frame();
        frame_spec_t fs;
        fs = random_spec();
        fs.payload_n = 205;
        fs.tot_len = 16'(WORD_BYTES * (fs.ihl + fs.thl) + fs.payload_n);
        send_frame(fs);
    endtask

    // receiver holds off while short frames keep coming, so the block backs up
    task automatic test_backpressure();
        frame_spec_t fs;
        sender_gaps = 1'b0;
        rx_hold_req = 1'b1;
        repeat (40) begin
            fs = random_spec();
            fs.cut = $urandom_range(1, 3);
            send_frame(fs);
        end
        send_frame(random_spec());
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        int          bytes_goal;
        int          frames_goal;
        int          r;
        frame_spec_t fs;
        bytes_goal  = bytes_sent + RANDOM_BYTES;
        frames_goal = frames_done + RANDOM_FRAMES_MIN;
        while (bytes_sent < bytes_goal || frames_done < frames_goal) begin
            r  = $urandom_range(99);
            fs = random_spec();
            if (r < 93) begin
                if (r >= 55 && r < 63) begin
                    fs.etype = $urandom_range(1) ? TYPE_IPV6 : 16'($urandom);
                end else if (r >= 63 && r < 69) begin
                    fs.ihl = 4'($urandom_range(0, 4));
                end else if (r >= 69 && r < 75) begin
                    fs.proto = 8'($urandom);
                    if (fs.proto == PROTO_TCP) fs.proto = PROTO_UDP;
                end else if (r >= 75 && r < 81) begin
                    fs.thl = 4'($urandom_range(0, 4));
                end else if (r >= 81) begin
                    fs.cut = $urandom_range(1, header_bytes(fs));
                end
                send_frame(fs);
            end else begin
                send_noise($urandom_range(1, 60));
            end
        end
    endtask

    initial begin
        clear_frame();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_good_frames();
        test_length_clamp();
        test_rejections();
        test_truncation();
        test_long_frame();
        test_backpressure();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Parsed %0d bytes in %0d frames; %0d results checked, %0d mismatches.",
                 bytes_sent, frames_done, reports_checked, errors);
        $display("Status mix: ok %0d, not ipv4 %0d, bad ip len %0d, not tcp %0d,",
                 status_hits[ST_OK], status_hits[ST_NOT_IPV4], status_hits[ST_BAD_IP_LEN],
                 status_hits[ST_NOT_TCP]);
        $display("  bad tcp len %0d, truncated %0d",
                 status_hits[ST_BAD_TCP_LEN], status_hits[ST_TRUNCATED]);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
